// ===== rtl/tts_pkg.sv =====
// Shared types and constants of the source text tokenizer.
// Token kind codes, keyword table, result beat layout.
// Depends on nothing; imported by every other file of the block.
package tts_pkg;

	localparam int OFF_W  = 24;
	localparam int LINE_W = 20;
	localparam int COL_W  = 16;
	localparam int LEN_W  = 16;
	localparam int MAX_RES = 4;
	localparam int NKW = 21;

	localparam int DEF_OFFSET_BITS = 24;
	localparam int DEF_LINE_BITS   = 20;
	localparam int DEF_COLUMN_BITS = 16;

	// Token kinds; keywords are 0..20
	localparam logic [6:0] K_KW_AND      = 7'd0;
	localparam logic [6:0] K_KW_OR       = 7'd14;
	localparam logic [6:0] K_IDENT       = 7'd21;
	localparam logic [6:0] K_NUMBER      = 7'd22;
	localparam logic [6:0] K_STRING      = 7'd23;
	localparam logic [6:0] K_LPAREN      = 7'd24;
	localparam logic [6:0] K_RPAREN      = 7'd25;
	localparam logic [6:0] K_LBRACE      = 7'd26;
	localparam logic [6:0] K_RBRACE      = 7'd27;
	localparam logic [6:0] K_LBRACKET    = 7'd28;
	localparam logic [6:0] K_RBRACKET    = 7'd29;
	localparam logic [6:0] K_SEMI        = 7'd30;
	localparam logic [6:0] K_COLON       = 7'd31;
	localparam logic [6:0] K_COMMA       = 7'd32;
	localparam logic [6:0] K_DOT         = 7'd33;
	localparam logic [6:0] K_DOT3        = 7'd34;
	localparam logic [6:0] K_AT          = 7'd35;
	localparam logic [6:0] K_MINUS       = 7'd36;
	localparam logic [6:0] K_MINUS_EQ    = 7'd37;
	localparam logic [6:0] K_MINUS_MINUS = 7'd38;
	localparam logic [6:0] K_PLUS        = 7'd39;
	localparam logic [6:0] K_PLUS_EQ     = 7'd40;
	localparam logic [6:0] K_PLUS_PLUS   = 7'd41;
	localparam logic [6:0] K_SLASH       = 7'd42;
	localparam logic [6:0] K_SLASH_EQ    = 7'd43;
	localparam logic [6:0] K_STAR        = 7'd44;
	localparam logic [6:0] K_STAR_EQ     = 7'd45;
	localparam logic [6:0] K_PERCENT     = 7'd46;
	localparam logic [6:0] K_PERCENT_EQ  = 7'd47;
	localparam logic [6:0] K_QUESTION    = 7'd48;
	localparam logic [6:0] K_BANG        = 7'd49;
	localparam logic [6:0] K_BANG_EQ     = 7'd50;
	localparam logic [6:0] K_EQ          = 7'd51;
	localparam logic [6:0] K_EQ_EQ       = 7'd52;
	localparam logic [6:0] K_FAT_ARROW   = 7'd53;
	localparam logic [6:0] K_BAND        = 7'd54;
	localparam logic [6:0] K_BAND_EQ     = 7'd55;
	localparam logic [6:0] K_BOR         = 7'd56;
	localparam logic [6:0] K_BOR_EQ      = 7'd57;
	localparam logic [6:0] K_BXOR        = 7'd58;
	localparam logic [6:0] K_BXOR_EQ     = 7'd59;
	localparam logic [6:0] K_BNOT        = 7'd60;
	localparam logic [6:0] K_LESS        = 7'd61;
	localparam logic [6:0] K_LESS_EQ     = 7'd62;
	localparam logic [6:0] K_SHL         = 7'd63;
	localparam logic [6:0] K_SHL_EQ      = 7'd64;
	localparam logic [6:0] K_GREATER     = 7'd65;
	localparam logic [6:0] K_GREATER_EQ  = 7'd66;
	localparam logic [6:0] K_SHR         = 7'd67;
	localparam logic [6:0] K_SHR_EQ      = 7'd68;
	localparam logic [6:0] K_USHR        = 7'd69;
	localparam logic [6:0] K_USHR_EQ     = 7'd70;
	localparam logic [6:0] K_EOF         = 7'd71;
	localparam logic [6:0] K_ERROR       = 7'd72;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_UNTERM   = 2'd1;
	localparam logic [1:0] ERR_BAD_BYTE = 2'd2;

	// Keyword text, right-justified: first character in the highest used byte
	localparam logic [63:0] KW_TEXT [0:NKW-1] = '{
		64'("and"), 64'("break"), 64'("case"), 64'("continue"), 64'("default"),
		64'("do"), 64'("else"), 64'("enum"), 64'("false"), 64'("for"),
		64'("func"), 64'("goto"), 64'("if"), 64'("null"), 64'("or"),
		64'("return"), 64'("struct"), 64'("switch"), 64'("true"), 64'("var"),
		64'("while")
	};
	localparam logic [3:0] KW_LEN [0:NKW-1] = '{
		4'd3, 4'd5, 4'd4, 4'd8, 4'd7, 4'd2, 4'd4, 4'd4, 4'd5, 4'd3, 4'd4,
		4'd4, 4'd2, 4'd4, 4'd2, 4'd6, 4'd6, 4'd6, 4'd4, 4'd3, 4'd5
	};

	typedef struct packed {
		logic [6:0]        kind;
		logic [1:0]        err;
		logic [7:0]        bad;
		logic [OFF_W-1:0]  soff;
		logic [LEN_W-1:0]  len;
		logic [LINE_W-1:0] fl;
		logic [COL_W-1:0]  fc;
		logic [LINE_W-1:0] ll;
		logic [COL_W-1:0]  lc;
	} res_t;

	// Character i of keyword k, zero past its end
	function automatic logic [7:0] kw_char(int k, int i);
		logic [7:0] ch;
		ch = 8'h00;
		if (k >= 0 && k < NKW && i < int'(KW_LEN[k]))
			ch = KW_TEXT[k][8*(int'(KW_LEN[k])-1-i) +: 8];
		return ch;
	endfunction

	// Advance the keyword trie by one character
	function automatic logic [4:0] trie_next(logic [4:0] node, logic [LEN_W-1:0] depth,
			logic [7:0] c);
		logic [4:0] nxt;
		logic       found;
		logic       match;
		logic [2:0] d3;
		nxt = 5'd0;
		found = 1'b0;
		d3 = depth[2:0];
		if (depth < LEN_W'(8) &&
				!(depth != '0 && (node == 5'd0 || node > 5'(NKW)))) begin
			for (int k = 0; k < NKW; k++) begin
				match = (KW_LEN[k] > {1'b0, d3});
				for (int i = 0; i < 8; i++) begin
					if (i < int'(d3) && kw_char(k, i) != kw_char(int'(node) - 1, i))
						match = 1'b0;
				end
				if (!found && match && kw_char(k, int'(d3)) == c) begin
					found = 1'b1;
					nxt = 5'(k + 1);
				end
			end
		end
		return nxt;
	endfunction

endpackage

// ===== rtl/tts_ifs.sv =====
// Channel interfaces of the source text tokenizer: byte input, token output,
// file number write port. Depends on tts_pkg.
interface tts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       end_of_text;
	modport source (output valid, source_byte, end_of_text, input ready);
	modport sink (input valid, source_byte, end_of_text, output ready);
endinterface

interface tts_token_if import tts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [6:0]        token_kind;
	logic [1:0]        error_kind;
	logic [7:0]        bad_byte;
	logic [OFF_W-1:0]  start_offset;
	logic [LEN_W-1:0]  token_length;
	logic [LINE_W-1:0] first_line;
	logic [COL_W-1:0]  first_column;
	logic [LINE_W-1:0] final_line;
	logic [COL_W-1:0]  final_column;
	logic              last_of_run;
	modport source (output valid, token_kind, error_kind, bad_byte, start_offset,
		token_length, first_line, first_column, final_line, final_column,
		last_of_run, input ready);
	modport sink (input valid, token_kind, error_kind, bad_byte, start_offset,
		token_length, first_line, first_column, final_line, final_column,
		last_of_run, output ready);
endinterface

interface tts_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] file_number;
	modport source (output valid, file_number, input ready);
	modport sink (input valid, file_number, output ready);
endinterface

// ===== rtl/tts_core.sv =====
// Scanner state and single-pass step logic: one byte in, up to three tokens out.
// Depends on tts_pkg.
module tts_core import tts_pkg::*; #(
	parameter int OFFSET_BITS = DEF_OFFSET_BITS,
	parameter int LINE_BITS   = DEF_LINE_BITS,
	parameter int COLUMN_BITS = DEF_COLUMN_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_in,
	input  logic       end_in,
	output res_t       res [0:MAX_RES-1],
	output logic [2:0] res_cnt
);

	typedef enum logic [29:0] {
		M_IDLE       = 30'd1 << 0,
		M_IDENT      = 30'd1 << 1,
		M_ZERO       = 30'd1 << 2,
		M_DEC        = 30'd1 << 3,
		M_DOT_HELD   = 30'd1 << 4,
		M_FRAC       = 30'd1 << 5,
		M_HEX        = 30'd1 << 6,
		M_BIN        = 30'd1 << 7,
		M_STRING     = 30'd1 << 8,
		M_SLASH      = 30'd1 << 9,
		M_LINE_C     = 30'd1 << 10,
		M_BLOCK_C    = 30'd1 << 11,
		M_BLOCK_STAR = 30'd1 << 12,
		M_DOT1       = 30'd1 << 13,
		M_DOT2       = 30'd1 << 14,
		M_MINUS      = 30'd1 << 15,
		M_PLUS       = 30'd1 << 16,
		M_STAR       = 30'd1 << 17,
		M_PERCENT    = 30'd1 << 18,
		M_BANG       = 30'd1 << 19,
		M_EQUAL      = 30'd1 << 20,
		M_AMP        = 30'd1 << 21,
		M_PIPE       = 30'd1 << 22,
		M_CARET      = 30'd1 << 23,
		M_LESS       = 30'd1 << 24,
		M_LESS2      = 30'd1 << 25,
		M_GREATER    = 30'd1 << 26,
		M_GREATER2   = 30'd1 << 27,
		M_GREATER3   = 30'd1 << 28,
		M_DONE       = 30'd1 << 29
	} mode_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] off;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic [LEN_W-1:0]       lbytes;
	} pos_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] soff;
		logic [LINE_BITS-1:0]   sline;
		logic [COLUMN_BITS-1:0] scol;
	} lex_t;

	mode_t      mode_q, m_v;
	pos_t       pos_q, p_v;
	lex_t       lex_q, lx_v;
	logic [4:0] kw_q, kw_v;
	logic       esc_q, esc_v;
	logic [7:0] held_q, held_v;
	res_t       res_v [0:MAX_RES-1];
	logic [2:0] n_v;
	logic       busy, brk;
	logic [6:0] sk;
	mode_t      nm;

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Count one consumed byte, saturating every counter
	function automatic pos_t take(pos_t p, logic [7:0] c);
		pos_t r;
		r = p;
		if (p.off != '1) r.off = p.off + 1'b1;
		if (c == 8'h0A) begin
			if (p.line != '1) r.line = p.line + 1'b1;
			r.col = COLUMN_BITS'(1);
		end else if (p.col != '1) begin
			r.col = p.col + 1'b1;
		end
		if (p.lbytes != '1) r.lbytes = p.lbytes + 1'b1;
		return r;
	endfunction

	function automatic res_t tok(logic [6:0] k, lex_t l, pos_t p);
		res_t r;
		r = '0;
		r.kind = k;
		r.soff = OFF_W'(l.soff);
		r.len  = p.lbytes;
		r.fl   = LINE_W'(l.sline);
		r.fc   = COL_W'(l.scol);
		r.ll   = LINE_W'(p.line);
		r.lc   = COL_W'(p.col);
		return r;
	endfunction

	function automatic res_t here(logic [6:0] k, logic [1:0] e, logic [7:0] b, pos_t p);
		res_t r;
		r = '0;
		r.kind = k;
		r.err  = e;
		r.bad  = b;
		r.soff = OFF_W'(p.off);
		r.fl   = LINE_W'(p.line);
		r.fc   = COL_W'(p.col);
		r.ll   = LINE_W'(p.line);
		r.lc   = COL_W'(p.col);
		return r;
	endfunction

	function automatic logic [6:0] pending_kind(mode_t m, logic [4:0] kw,
			logic [LEN_W-1:0] lb);
		logic [6:0] k;
		case (m)
			M_IDENT: begin
				k = K_IDENT;
				if (kw != 5'd0 && kw <= 5'(NKW) && LEN_W'(KW_LEN[kw - 5'd1]) == lb)
					k = 7'(kw - 5'd1);
			end
			M_ZERO, M_DEC, M_DOT_HELD, M_FRAC, M_HEX, M_BIN: k = K_NUMBER;
			M_SLASH:    k = K_SLASH;
			M_DOT1, M_DOT2: k = K_DOT;
			M_MINUS:    k = K_MINUS;
			M_PLUS:     k = K_PLUS;
			M_STAR:     k = K_STAR;
			M_PERCENT:  k = K_PERCENT;
			M_BANG:     k = K_BANG;
			M_EQUAL:    k = K_EQ;
			M_AMP:      k = K_BAND;
			M_PIPE:     k = K_BOR;
			M_CARET:    k = K_BXOR;
			M_LESS:     k = K_LESS;
			M_LESS2:    k = K_SHL;
			M_GREATER:  k = K_GREATER;
			M_GREATER2: k = K_SHR;
			M_GREATER3: k = K_USHR;
			default:    k = K_ERROR;
		endcase
		return k;
	endfunction

	// Single-byte tokens; error code means none
	function automatic logic [6:0] single_kind(logic [7:0] c);
		logic [6:0] k;
		case (c)
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			"[":     k = K_LBRACKET;
			"]":     k = K_RBRACKET;
			";":     k = K_SEMI;
			":":     k = K_COLON;
			",":     k = K_COMMA;
			"@":     k = K_AT;
			"?":     k = K_QUESTION;
			"~":     k = K_BNOT;
			default: k = K_ERROR;
		endcase
		return k;
	endfunction

	function automatic mode_t open_mode(logic [7:0] c);
		mode_t m;
		case (c)
			".":     m = M_DOT1;
			"-":     m = M_MINUS;
			"+":     m = M_PLUS;
			"/":     m = M_SLASH;
			"*":     m = M_STAR;
			"%":     m = M_PERCENT;
			"!":     m = M_BANG;
			"=":     m = M_EQUAL;
			"&":     m = M_AMP;
			"|":     m = M_PIPE;
			"^":     m = M_CARET;
			"<":     m = M_LESS;
			">":     m = M_GREATER;
			8'h22:   m = M_STRING;
			default: m = M_IDLE;
		endcase
		return m;
	endfunction

	// Work one byte through the scanner, rescanning up to twice
	always_comb begin
		m_v = mode_q;
		p_v = pos_q;
		lx_v = lex_q;
		kw_v = kw_q;
		esc_v = esc_q;
		held_v = held_q;
		n_v = 3'd0;
		busy = 1'b0;
		brk = 1'b0;
		sk = K_ERROR;
		nm = M_IDLE;
		for (int j = 0; j < MAX_RES; j++) res_v[j] = '0;

		if (mode_q == M_DONE) begin
			res_v[n_v[1:0]] = here(K_EOF, ERR_NONE, 8'h00, p_v);
			n_v = n_v + 3'd1;
		end else if (end_in || byte_in == 8'h00) begin
			// flush the pending token, then EOF
			if (m_v == M_DOT_HELD) begin
				res_v[n_v[1:0]] = tok(K_NUMBER, lx_v, p_v);
				n_v = n_v + 3'd1;
				lx_v = '{soff: p_v.off, sline: p_v.line, scol: p_v.col};
				p_v.lbytes = '0;
				kw_v = 5'd0;
				p_v = take(p_v, held_v);
				res_v[n_v[1:0]] = tok(K_DOT, lx_v, p_v);
				n_v = n_v + 3'd1;
			end else if (m_v == M_STRING) begin
				res_v[n_v[1:0]] = here(K_ERROR, ERR_UNTERM, 8'h00, p_v);
				n_v = n_v + 3'd1;
			end else if (!(m_v inside {M_IDLE, M_LINE_C, M_BLOCK_C, M_BLOCK_STAR})) begin
				res_v[n_v[1:0]] = tok(pending_kind(m_v, kw_v, p_v.lbytes), lx_v, p_v);
				n_v = n_v + 3'd1;
			end
			esc_v = 1'b0;
			res_v[n_v[1:0]] = here(K_EOF, ERR_NONE, 8'h00, p_v);
			n_v = n_v + 3'd1;
			m_v = M_DONE;
		end else begin
			busy = 1'b1;
			for (int it = 0; it < 3; it++) begin
				if (busy) begin
					busy = 1'b0;
					brk = 1'b0;
					case (m_v)
						M_IDLE: begin
							if (byte_in inside {8'h20, 8'h0D, 8'h09, 8'h0A}) begin
								p_v = take(p_v, byte_in);
							end else begin
								lx_v = '{soff: p_v.off, sline: p_v.line, scol: p_v.col};
								p_v.lbytes = '0;
								kw_v = 5'd0;
								esc_v = 1'b0;
								if (is_alpha(byte_in)) begin
									kw_v = trie_next(5'd0, '0, byte_in);
									p_v = take(p_v, byte_in);
									m_v = M_IDENT;
								end else if (is_dig(byte_in)) begin
									p_v = take(p_v, byte_in);
									m_v = (byte_in == "0") ? M_ZERO : M_DEC;
								end else begin
									sk = single_kind(byte_in);
									nm = open_mode(byte_in);
									p_v = take(p_v, byte_in);
									if (sk != K_ERROR) begin
										res_v[n_v[1:0]] = tok(sk, lx_v, p_v);
										n_v = n_v + 3'd1;
									end else if (nm != M_IDLE) begin
										m_v = nm;
									end else begin
										res_v[n_v[1:0]] = here(K_ERROR, ERR_BAD_BYTE,
											byte_in, p_v);
										n_v = n_v + 3'd1;
									end
								end
							end
						end
						M_IDENT: begin
							if (is_alpha(byte_in) || is_dig(byte_in)) begin
								kw_v = trie_next(kw_v, p_v.lbytes, byte_in);
								p_v = take(p_v, byte_in);
							end else brk = 1'b1;
						end
						M_ZERO: begin
							if (byte_in == "x" || byte_in == "X") begin
								p_v = take(p_v, byte_in);
								m_v = M_HEX;
							end else if (byte_in == "b" || byte_in == "B") begin
								p_v = take(p_v, byte_in);
								m_v = M_BIN;
							end else begin
								m_v = M_DEC;
								busy = 1'b1;
							end
						end
						M_DEC: begin
							if (is_dig(byte_in) || byte_in == "_") begin
								p_v = take(p_v, byte_in);
							end else if (byte_in == ".") begin
								held_v = byte_in;
								m_v = M_DOT_HELD;
							end else brk = 1'b1;
						end
						M_DOT_HELD: begin
							if (is_dig(byte_in)) begin
								p_v = take(p_v, held_v);
								p_v = take(p_v, byte_in);
								m_v = M_FRAC;
							end else begin
								// number ends; rescan the held dot
								res_v[n_v[1:0]] = tok(K_NUMBER, lx_v, p_v);
								n_v = n_v + 3'd1;
								lx_v = '{soff: p_v.off, sline: p_v.line, scol: p_v.col};
								p_v.lbytes = '0;
								kw_v = 5'd0;
								esc_v = 1'b0;
								p_v = take(p_v, held_v);
								m_v = M_DOT1;
								busy = 1'b1;
							end
						end
						M_FRAC: begin
							if (is_dig(byte_in) || byte_in == "_") p_v = take(p_v, byte_in);
							else brk = 1'b1;
						end
						M_HEX: begin
							if (is_dig(byte_in) || (byte_in >= "a" && byte_in <= "f") ||
									(byte_in >= "A" && byte_in <= "F") || byte_in == "_")
								p_v = take(p_v, byte_in);
							else brk = 1'b1;
						end
						M_BIN: begin
							if (byte_in == "0" || byte_in == "1" || byte_in == "_")
								p_v = take(p_v, byte_in);
							else brk = 1'b1;
						end
						M_STRING: begin
							p_v = take(p_v, byte_in);
							if (esc_v) esc_v = 1'b0;
							else if (byte_in == 8'h5C) esc_v = 1'b1;
							else if (byte_in == 8'h22) begin
								res_v[n_v[1:0]] = tok(K_STRING, lx_v, p_v);
								n_v = n_v + 3'd1;
								m_v = M_IDLE;
							end
						end
						M_LINE_C: begin
							if (byte_in == 8'h0A) begin
								m_v = M_IDLE;
								busy = 1'b1;
							end else p_v = take(p_v, byte_in);
						end
						M_BLOCK_C: begin
							p_v = take(p_v, byte_in);
							if (byte_in == "*") m_v = M_BLOCK_STAR;
						end
						M_BLOCK_STAR: begin
							p_v = take(p_v, byte_in);
							if (byte_in == "/") m_v = M_IDLE;
							else if (byte_in != "*") m_v = M_BLOCK_C;
						end
						M_SLASH, M_DOT1, M_LESS, M_GREATER, M_GREATER2: begin
							// operators that can grow into a longer mode
							nm = M_IDLE;
							sk = K_ERROR;
							case (m_v)
								M_SLASH: begin
									if (byte_in == "/") nm = M_LINE_C;
									else if (byte_in == "*") nm = M_BLOCK_C;
									else if (byte_in == "=") sk = K_SLASH_EQ;
								end
								M_DOT1: if (byte_in == ".") nm = M_DOT2;
								M_LESS: begin
									if (byte_in == "<") nm = M_LESS2;
									else if (byte_in == "=") sk = K_LESS_EQ;
								end
								M_GREATER: begin
									if (byte_in == ">") nm = M_GREATER2;
									else if (byte_in == "=") sk = K_GREATER_EQ;
								end
								default: begin
									if (byte_in == ">") nm = M_GREATER3;
									else if (byte_in == "=") sk = K_SHR_EQ;
								end
							endcase
							if (nm != M_IDLE) begin
								p_v = take(p_v, byte_in);
								m_v = nm;
							end else if (sk != K_ERROR) begin
								p_v = take(p_v, byte_in);
								res_v[n_v[1:0]] = tok(sk, lx_v, p_v);
								n_v = n_v + 3'd1;
								m_v = M_IDLE;
							end else brk = 1'b1;
						end
						M_DOT2, M_MINUS, M_PLUS, M_STAR, M_PERCENT, M_BANG, M_EQUAL,
						M_AMP, M_PIPE, M_CARET, M_LESS2, M_GREATER3: begin
							// operators closed by one more byte
							sk = K_ERROR;
							case (m_v)
								M_DOT2:    if (byte_in == ".") sk = K_DOT3;
								M_MINUS: begin
									if (byte_in == "=") sk = K_MINUS_EQ;
									else if (byte_in == "-") sk = K_MINUS_MINUS;
								end
								M_PLUS: begin
									if (byte_in == "=") sk = K_PLUS_EQ;
									else if (byte_in == "+") sk = K_PLUS_PLUS;
								end
								M_STAR:    if (byte_in == "=") sk = K_STAR_EQ;
								M_PERCENT: if (byte_in == "=") sk = K_PERCENT_EQ;
								M_BANG:    if (byte_in == "=") sk = K_BANG_EQ;
								M_EQUAL: begin
									if (byte_in == "=") sk = K_EQ_EQ;
									else if (byte_in == ">") sk = K_FAT_ARROW;
								end
								M_AMP: begin
									if (byte_in == "&") sk = K_KW_AND;
									else if (byte_in == "=") sk = K_BAND_EQ;
								end
								M_PIPE: begin
									if (byte_in == "|") sk = K_KW_OR;
									else if (byte_in == "=") sk = K_BOR_EQ;
								end
								M_CARET:   if (byte_in == "=") sk = K_BXOR_EQ;
								M_LESS2:   if (byte_in == "=") sk = K_SHL_EQ;
								default:   if (byte_in == "=") sk = K_USHR_EQ;
							endcase
							if (sk != K_ERROR) begin
								p_v = take(p_v, byte_in);
								res_v[n_v[1:0]] = tok(sk, lx_v, p_v);
								n_v = n_v + 3'd1;
								m_v = M_IDLE;
							end else brk = 1'b1;
						end
						default: begin
							m_v = M_IDLE;
							busy = 1'b1;
						end
					endcase
					// byte does not extend the token: emit it and rescan
					if (brk) begin
						res_v[n_v[1:0]] = tok(pending_kind(m_v, kw_v, p_v.lbytes), lx_v, p_v);
						n_v = n_v + 3'd1;
						m_v = M_IDLE;
						busy = 1'b1;
					end
				end
			end
		end
	end

	assign res = res_v;
	assign res_cnt = n_v;

	// Advance scanner state on each processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			kw_q <= 5'd0;
			esc_q <= 1'b0;
			pos_q <= '{off: '0, line: LINE_BITS'(1), col: COLUMN_BITS'(1), lbytes: '0};
			lex_q <= '{soff: '0, sline: LINE_BITS'(1), scol: COLUMN_BITS'(1)};
		end else if (step) begin
			mode_q <= m_v;
			kw_q <= kw_v;
			esc_q <= esc_v;
			pos_q <= p_v;
			lex_q <= lx_v;
		end
	end

	// Hold the dot after a number
	always_ff @(posedge clk) begin
		if (step) held_q <= held_v;
	end

endmodule

// ===== rtl/tts_outq.sv =====
// Result buffer: holds the tokens of one step and sends them one beat a cycle while the receiver is ready.
// Depends on tts_pkg and the token interface.
module tts_outq import tts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_t       res_in [0:MAX_RES-1],
	input  logic [2:0] res_cnt,
	output logic       free,
	tts_token_if.source tok
);

	res_t       buf_q [0:MAX_RES-1];
	logic [1:0] rd_q;
	logic [2:0] rem_q;
	logic       pop;
	res_t       cur;

	assign pop = tok.valid && tok.ready;
	assign free = (rem_q == 3'd0) || (rem_q == 3'd1 && pop);
	assign cur = buf_q[rd_q];

	// Drive the current beat
	assign tok.valid        = (rem_q != 3'd0);
	assign tok.token_kind   = cur.kind;
	assign tok.error_kind   = cur.err;
	assign tok.bad_byte     = cur.bad;
	assign tok.start_offset = cur.soff;
	assign tok.token_length = cur.len;
	assign tok.first_line   = cur.fl;
	assign tok.first_column = cur.fc;
	assign tok.final_line   = cur.ll;
	assign tok.final_column = cur.lc;
	assign tok.last_of_run  = (rem_q == 3'd1);

	// Load a new step's tokens or advance through the current ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 2'd0;
			rem_q <= 3'd0;
		end else if (load) begin
			rd_q <= 2'd0;
			rem_q <= res_cnt;
		end else if (pop) begin
			rd_q <= rd_q + 2'd1;
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) buf_q <= res_in;
	end

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// Source text tokenizer: input register, scanner step, result buffer.
// Depends on tts_pkg, tts_ifs, tts_core, tts_outq.
//
// Usage:
//   src_in  : one source byte per beat; end_of_text or a zero byte ends the
//             text, flushes the pending token and sends EOF. Every later beat
//             gives one more EOF.
//   tok_out : one token per beat; last_of_run marks the final token of a
//             source beat. A beat that makes no token (blank, comment byte)
//             makes no output beat.
//   cfg     : writes file_number; always ready, write only while idle.
// Timing: a byte registers on acceptance, is scanned once the result buffer is
// free, and its tokens are registered into the result buffer. One byte a cycle
// is taken while each byte gives at most one token and the receiver is ready;
// a byte that gives more tokens holds the scanner while the result buffer drains.
// A receiver stall holds the result buffer, then the input register, then
// src_in.ready. Reset clears the control state to line 1, column 1, offset 0.
module source_text_tokenizer import tts_pkg::*; #(
	parameter int OFFSET_BITS = DEF_OFFSET_BITS,
	parameter int LINE_BITS   = DEF_LINE_BITS,
	parameter int COLUMN_BITS = DEF_COLUMN_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	tts_byte_if.sink    src_in,
	tts_token_if.source tok_out,
	tts_cfg_if.sink     cfg
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        step;
	logic        free;
	res_t        res [0:MAX_RES-1];
	logic [2:0]  res_cnt;
	logic [15:0] file_number_q;

	assign step = valid_s1 && free;
	assign src_in.ready = !valid_s1 || step;
	assign cfg.ready = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_in.ready) begin
			valid_s1 <= src_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_in.valid && src_in.ready) begin
			byte_s1 <= src_in.source_byte;
			end_s1 <= src_in.end_of_text;
		end
	end

	// File number register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_number_q <= 16'd0;
		end else if (cfg.valid) begin
			file_number_q <= cfg.file_number;
		end
	end

	tts_core #(
		.OFFSET_BITS (OFFSET_BITS),
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.end_in  (end_s1),
		.res     (res),
		.res_cnt (res_cnt)
	);

	tts_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step),
		.res_in  (res),
		.res_cnt (res_cnt),
		.free    (free),
		.tok     (tok_out)
	);

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of source_text_tokenizer: byte stream in, tokens out.
// Holds its own scanner model for expected tokens; depends on tts_pkg, tts_ifs and source_text_tokenizer.
module testbench;
	import tts_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 10;
	localparam int RANDOM_BYTES   = 450;
	localparam logic [31:0] OFF_MAX  = (32'd1 << OFF_W) - 1;
	localparam logic [31:0] LINE_MAX = (32'd1 << LINE_W) - 1;
	localparam logic [31:0] COL_MAX  = (32'd1 << COL_W) - 1;

	typedef enum logic [4:0] {
		SC_IDLE, SC_IDENT, SC_ZERO, SC_DEC, SC_DOT_HELD, SC_FRAC, SC_HEX, SC_BIN,
		SC_STRING, SC_SLASH, SC_LINE_C, SC_BLOCK_C, SC_BLOCK_STAR, SC_DOT1, SC_DOT2,
		SC_MINUS, SC_PLUS, SC_STAR, SC_PERCENT, SC_BANG, SC_EQUAL, SC_AMP, SC_PIPE,
		SC_CARET, SC_LESS, SC_LESS2, SC_GREATER, SC_GREATER2, SC_GREATER3, SC_DONE
	} scan_state_t;

	typedef struct packed {
		res_t r;
		logic last;
	} token_beat_t;

	typedef struct {
		logic [7:0] b;
		logic       e;
	} src_beat_t;

	logic clk;
	logic arst_n;

	tts_byte_if  src_in ();
	tts_token_if tok_out ();
	tts_cfg_if   cfg ();

	source_text_tokenizer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src_in (src_in.sink),
		.tok_out(tok_out.source),
		.cfg    (cfg.sink)
	);

	string keywords [NKW] = '{"and", "break", "case", "continue", "default", "do", "else",
		"enum", "false", "for", "func", "goto", "if", "null", "or", "return", "struct",
		"switch", "true", "var", "while"};
	string operators [44] = '{"(", ")", "{", "}", "[", "]", ";", ":", ",", ".", "...", "..",
		"@", "-", "-=", "--", "+", "+=", "++", "/", "/=", "*", "*=", "%", "%=", "?", "!",
		"!=", "=", "==", "=>", "&", "&=", "|", "|=", "^", "^=", "~", "<", "<=", "<<",
		"<<=", ">", ">>>="};

	// Scanner model state
	scan_state_t scan_mode;
	int          trie_node;
	logic [31:0] pos_now, line_now, col_now;
	logic [31:0] lex_off, lex_line, lex_col, lex_len;
	logic        in_escape;
	logic [15:0] file_id;

	token_beat_t step_tokens [$];
	token_beat_t expected_tokens [$];
	src_beat_t   pending_bytes [$];

	int  mismatches;
	int  beats_in;
	int  beats_out;
	int  idle_cycles;
	logic hold_off;

	// Clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] sat_inc(logic [31:0] v, logic [31:0] lim);
		return (v >= lim) ? lim : v + 1;
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void take_byte(logic [7:0] c);
		pos_now = sat_inc(pos_now, OFF_MAX);
		if (c == 8'h0A) begin
			line_now = sat_inc(line_now, LINE_MAX);
			col_now = 1;
		end else begin
			col_now = sat_inc(col_now, COL_MAX);
		end
		if (lex_len < 32'hFFFF)
			lex_len++;
	endfunction

	function automatic void open_lexeme();
		lex_off = pos_now;
		lex_line = line_now;
		lex_col = col_now;
		lex_len = 0;
		trie_node = 0;
		in_escape = 1'b0;
	endfunction

	// Walk the keyword trie one character deeper
	function automatic int trie_step(int node, logic [31:0] depth, logic [7:0] c);
		bit same;
		if (depth >= 8)
			return 0;
		if (depth > 0 && (node == 0 || node > NKW))
			return 0;
		for (int k = 0; k < NKW; k++) begin
			if (keywords[k].len() <= depth)
				continue;
			same = 1'b1;
			for (int i = 0; i < depth; i++)
				if (keywords[k][i] != keywords[node-1][i])
					same = 1'b0;
			if (same && keywords[k][depth] == c)
				return k + 1;
		end
		return 0;
	endfunction

	function automatic void add_token(logic [6:0] kind, logic [1:0] err, logic [7:0] bad,
			logic [31:0] soff, logic [31:0] len, logic [31:0] fl, logic [31:0] fc);
		token_beat_t t;
		if (step_tokens.size() >= MAX_RES)
			return;
		t.r.kind = kind;
		t.r.err = err;
		t.r.bad = bad;
		t.r.soff = soff[OFF_W-1:0];
		t.r.len = len[LEN_W-1:0];
		t.r.fl = fl[LINE_W-1:0];
		t.r.fc = fc[COL_W-1:0];
		t.r.ll = line_now[LINE_W-1:0];
		t.r.lc = col_now[COL_W-1:0];
		t.last = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void emit_lexeme(logic [6:0] kind);
		add_token(kind, ERR_NONE, 8'h00, lex_off, lex_len, lex_line, lex_col);
	endfunction

	function automatic void emit_here(logic [6:0] kind, logic [1:0] err, logic [7:0] bad);
		add_token(kind, err, bad, pos_now, 0, line_now, col_now);
	endfunction

	function automatic logic [6:0] open_kind(scan_state_t m);
		case (m)
			SC_IDENT: begin
				if (trie_node != 0 && trie_node <= NKW &&
						keywords[trie_node-1].len() == lex_len)
					return 7'(trie_node - 1);
				return K_IDENT;
			end
			SC_ZERO, SC_DEC, SC_DOT_HELD, SC_FRAC, SC_HEX, SC_BIN: return K_NUMBER;
			SC_SLASH:    return K_SLASH;
			SC_DOT1, SC_DOT2: return K_DOT;
			SC_MINUS:    return K_MINUS;
			SC_PLUS:     return K_PLUS;
			SC_STAR:     return K_STAR;
			SC_PERCENT:  return K_PERCENT;
			SC_BANG:     return K_BANG;
			SC_EQUAL:    return K_EQ;
			SC_AMP:      return K_BAND;
			SC_PIPE:     return K_BOR;
			SC_CARET:    return K_BXOR;
			SC_LESS:     return K_LESS;
			SC_LESS2:    return K_SHL;
			SC_GREATER:  return K_GREATER;
			SC_GREATER2: return K_SHR;
			SC_GREATER3: return K_USHR;
			default:     return K_ERROR;
		endcase
	endfunction

	// Consume c and close the token when c is the wanted byte
	function automatic bit close_with(logic [7:0] c, logic [7:0] want, logic [6:0] kind);
		if (c != want)
			return 1'b0;
		take_byte(c);
		emit_lexeme(kind);
		scan_mode = SC_IDLE;
		return 1'b1;
	endfunction

	function automatic void start_token(logic [7:0] c);
		logic [6:0]  single;
		scan_state_t nxt;
		single = K_EOF;
		nxt = SC_IDLE;
		if (c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A) begin
			take_byte(c);
			return;
		end
		open_lexeme();
		if (is_alpha(c)) begin
			trie_node = trie_step(0, 0, c);
			take_byte(c);
			scan_mode = SC_IDENT;
			return;
		end
		if (is_digit(c)) begin
			take_byte(c);
			scan_mode = (c == "0") ? SC_ZERO : SC_DEC;
			return;
		end
		case (c)
			"(": single = K_LPAREN;
			")": single = K_RPAREN;
			"{": single = K_LBRACE;
			"}": single = K_RBRACE;
			"[": single = K_LBRACKET;
			"]": single = K_RBRACKET;
			";": single = K_SEMI;
			":": single = K_COLON;
			",": single = K_COMMA;
			"@": single = K_AT;
			"?": single = K_QUESTION;
			"~": single = K_BNOT;
			".": nxt = SC_DOT1;
			"-": nxt = SC_MINUS;
			"+": nxt = SC_PLUS;
			"/": nxt = SC_SLASH;
			"*": nxt = SC_STAR;
			"%": nxt = SC_PERCENT;
			"!": nxt = SC_BANG;
			"=": nxt = SC_EQUAL;
			"&": nxt = SC_AMP;
			"|": nxt = SC_PIPE;
			"^": nxt = SC_CARET;
			"<": nxt = SC_LESS;
			">": nxt = SC_GREATER;
			"\"": nxt = SC_STRING;
			default: ;
		endcase
		take_byte(c);
		if (single != K_EOF)
			emit_lexeme(single);
		else if (nxt != SC_IDLE)
			scan_mode = nxt;
		else
			emit_here(K_ERROR, ERR_BAD_BYTE, c);
	endfunction

	// Advance the scanner by one byte; a closed token makes the byte rescan
	function automatic void scan_byte(logic [7:0] c);
		scan_state_t m;
		bit closed;
		forever begin
			m = scan_mode;
			closed = 1'b0;
			case (m)
				SC_IDLE: begin
					start_token(c);
					return;
				end
				SC_IDENT: begin
					if (is_alpha(c) || is_digit(c)) begin
						trie_node = trie_step(trie_node, lex_len, c);
						take_byte(c);
						return;
					end
					closed = 1'b1;
				end
				SC_ZERO: begin
					if (c == "x" || c == "X") begin
						take_byte(c);
						scan_mode = SC_HEX;
						return;
					end
					if (c == "b" || c == "B") begin
						take_byte(c);
						scan_mode = SC_BIN;
						return;
					end
					scan_mode = SC_DEC;
				end
				SC_DEC: begin
					if (is_digit(c) || c == "_") begin
						take_byte(c);
						return;
					end
					if (c == ".") begin
						scan_mode = SC_DOT_HELD;
						return;
					end
					closed = 1'b1;
				end
				SC_DOT_HELD: begin
					if (is_digit(c)) begin
						take_byte(".");
						take_byte(c);
						scan_mode = SC_FRAC;
						return;
					end
					emit_lexeme(K_NUMBER);
					open_lexeme();
					take_byte(".");
					scan_mode = SC_DOT1;
				end
				SC_FRAC: begin
					if (is_digit(c) || c == "_") begin
						take_byte(c);
						return;
					end
					closed = 1'b1;
				end
				SC_HEX: begin
					if (is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") ||
							c == "_") begin
						take_byte(c);
						return;
					end
					closed = 1'b1;
				end
				SC_BIN: begin
					if (c == "0" || c == "1" || c == "_") begin
						take_byte(c);
						return;
					end
					closed = 1'b1;
				end
				SC_STRING: begin
					take_byte(c);
					if (in_escape)
						in_escape = 1'b0;
					else if (c == "\\")
						in_escape = 1'b1;
					else if (c == "\"") begin
						emit_lexeme(K_STRING);
						scan_mode = SC_IDLE;
					end
					return;
				end
				SC_SLASH: begin
					if (c == "/") begin
						take_byte(c);
						scan_mode = SC_LINE_C;
						return;
					end
					if (c == "*") begin
						take_byte(c);
						scan_mode = SC_BLOCK_C;
						return;
					end
					if (close_with(c, "=", K_SLASH_EQ))
						return;
					closed = 1'b1;
				end
				SC_LINE_C: begin
					if (c == 8'h0A)
						scan_mode = SC_IDLE;
					else begin
						take_byte(c);
						return;
					end
				end
				SC_BLOCK_C: begin
					take_byte(c);
					if (c == "*")
						scan_mode = SC_BLOCK_STAR;
					return;
				end
				SC_BLOCK_STAR: begin
					take_byte(c);
					if (c == "/")
						scan_mode = SC_IDLE;
					else if (c != "*")
						scan_mode = SC_BLOCK_C;
					return;
				end
				SC_DOT1: begin
					if (c == ".") begin
						take_byte(c);
						scan_mode = SC_DOT2;
						return;
					end
					closed = 1'b1;
				end
				SC_DOT2: begin
					if (close_with(c, ".", K_DOT3)) return;
					closed = 1'b1;
				end
				SC_MINUS: begin
					if (close_with(c, "=", K_MINUS_EQ) || close_with(c, "-", K_MINUS_MINUS))
						return;
					closed = 1'b1;
				end
				SC_PLUS: begin
					if (close_with(c, "=", K_PLUS_EQ) || close_with(c, "+", K_PLUS_PLUS))
						return;
					closed = 1'b1;
				end
				SC_STAR: begin
					if (close_with(c, "=", K_STAR_EQ)) return;
					closed = 1'b1;
				end
				SC_PERCENT: begin
					if (close_with(c, "=", K_PERCENT_EQ)) return;
					closed = 1'b1;
				end
				SC_BANG: begin
					if (close_with(c, "=", K_BANG_EQ)) return;
					closed = 1'b1;
				end
				SC_EQUAL: begin
					if (close_with(c, "=", K_EQ_EQ) || close_with(c, ">", K_FAT_ARROW))
						return;
					closed = 1'b1;
				end
				SC_AMP: begin
					if (close_with(c, "&", K_KW_AND) || close_with(c, "=", K_BAND_EQ))
						return;
					closed = 1'b1;
				end
				SC_PIPE: begin
					if (close_with(c, "|", K_KW_OR) || close_with(c, "=", K_BOR_EQ))
						return;
					closed = 1'b1;
				end
				SC_CARET: begin
					if (close_with(c, "=", K_BXOR_EQ)) return;
					closed = 1'b1;
				end
				SC_LESS: begin
					if (c == "<") begin
						take_byte(c);
						scan_mode = SC_LESS2;
						return;
					end
					if (close_with(c, "=", K_LESS_EQ)) return;
					closed = 1'b1;
				end
				SC_LESS2: begin
					if (close_with(c, "=", K_SHL_EQ)) return;
					closed = 1'b1;
				end
				SC_GREATER: begin
					if (c == ">") begin
						take_byte(c);
						scan_mode = SC_GREATER2;
						return;
					end
					if (close_with(c, "=", K_GREATER_EQ)) return;
					closed = 1'b1;
				end
				SC_GREATER2: begin
					if (c == ">") begin
						take_byte(c);
						scan_mode = SC_GREATER3;
						return;
					end
					if (close_with(c, "=", K_SHR_EQ)) return;
					closed = 1'b1;
				end
				SC_GREATER3: begin
					if (close_with(c, "=", K_USHR_EQ)) return;
					closed = 1'b1;
				end
				default: scan_mode = SC_IDLE;
			endcase
			if (closed) begin
				emit_lexeme(open_kind(m));
				scan_mode = SC_IDLE;
			end
		end
	endfunction

	// Flush the open token at end of text
	function automatic void flush_open();
		scan_state_t m;
		m = scan_mode;
		if (m == SC_DOT_HELD) begin
			emit_lexeme(K_NUMBER);
			open_lexeme();
			take_byte(".");
			emit_lexeme(K_DOT);
		end else if (m == SC_STRING) begin
			emit_here(K_ERROR, ERR_UNTERM, 8'h00);
		end else if (m != SC_IDLE && m != SC_LINE_C && m != SC_BLOCK_C &&
				m != SC_BLOCK_STAR && m != SC_DONE) begin
			emit_lexeme(open_kind(m));
		end
		in_escape = 1'b0;
	endfunction

	// Work out the tokens one accepted byte beat causes
	function automatic void predict_tokens(logic [7:0] b, logic e);
		step_tokens.delete();
		if (scan_mode == SC_DONE) begin
			emit_here(K_EOF, ERR_NONE, 8'h00);
		end else if (e || b == 8'h00) begin
			flush_open();
			emit_here(K_EOF, ERR_NONE, 8'h00);
			scan_mode = SC_DONE;
		end else begin
			scan_byte(b);
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size()-1].last = 1'b1;
		foreach (step_tokens[i])
			expected_tokens.push_back(step_tokens[i]);
	endfunction

	initial begin
		scan_mode = SC_IDLE;
		trie_node = 0;
		pos_now = 0;
		line_now = 1;
		col_now = 1;
		lex_off = 0;
		lex_line = 1;
		lex_col = 1;
		lex_len = 0;
		in_escape = 1'b0;
		file_id = '0;
		mismatches = 0;
		beats_in = 0;
		beats_out = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		arst_n = 1'b0;
		src_in.valid = 1'b0;
		src_in.source_byte = 8'h00;
		src_in.end_of_text = 1'b0;
		tok_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.file_number = 16'h0000;
	end

	// Byte driver: present queued beats with a random gap after each, none in quiet phases
	int  src_gap = 0;
	always @(posedge clk) begin
		src_beat_t nb;
		bit        quiet;
		if (arst_n) begin
			if (src_in.valid && src_in.ready) begin
				predict_tokens(src_in.source_byte, src_in.end_of_text);
				beats_in++;
			end
			if (!src_in.valid || src_in.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					src_in.valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					nb = pending_bytes.pop_front();
					src_in.valid <= 1'b1;
					src_in.source_byte <= nb.b;
					src_in.end_of_text <= nb.e;
					quiet = ((beats_in / 50) % 3) == 1;
					src_gap = quiet ? 0 : $urandom_range(0, 3);
				end else begin
					src_in.valid <= 1'b0;
				end
			end
		end
	end

	// Token monitor: compare each beat with the oldest expectation
	int tok_stall = 0;
	always @(posedge clk) begin
		token_beat_t want;
		bit          quiet;
		if (arst_n) begin
			if (tok_out.valid && tok_out.ready) begin
				beats_out++;
				if (expected_tokens.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected token beat: kind %0d at offset %0d",
							tok_out.token_kind, tok_out.start_offset);
				end else begin
					want = expected_tokens.pop_front();
					if (tok_out.token_kind !== want.r.kind || tok_out.error_kind !== want.r.err ||
							tok_out.bad_byte !== want.r.bad ||
							tok_out.start_offset !== want.r.soff ||
							tok_out.token_length !== want.r.len ||
							tok_out.first_line !== want.r.fl ||
							tok_out.first_column !== want.r.fc ||
							tok_out.final_line !== want.r.ll ||
							tok_out.final_column !== want.r.lc ||
							tok_out.last_of_run !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"token mismatch: expected kind %0d err %0d bad %0d off %0d ",
								"len %0d from %0d:%0d to %0d:%0d last %0d, got kind %0d err %0d ",
								"bad %0d off %0d len %0d from %0d:%0d to %0d:%0d last %0d"},
								want.r.kind, want.r.err, want.r.bad, want.r.soff, want.r.len,
								want.r.fl, want.r.fc, want.r.ll, want.r.lc, want.last,
								tok_out.token_kind, tok_out.error_kind, tok_out.bad_byte,
								tok_out.start_offset, tok_out.token_length, tok_out.first_line,
								tok_out.first_column, tok_out.final_line, tok_out.final_column,
								tok_out.last_of_run);
					end
				end
				quiet = ((beats_out / 40) % 3) == 2;
				tok_stall = quiet ? 0 : $urandom_range(0, 3);
			end
			if (hold_off) begin
				tok_out.ready <= 1'b0;
			end else if (tok_stall > 0) begin
				tok_stall--;
				tok_out.ready <= 1'b0;
			end else begin
				tok_out.ready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off while bytes keep coming, to back up the input
	initial begin
		wait (beats_in >= 200);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	// Watchdog on cycles with no beat moving anywhere
	int last_in = 0;
	int last_out = 0;
	always @(posedge clk) begin
		if (beats_in != last_in || beats_out != last_out || cfg.valid)
			idle_cycles = 0;
		else
			idle_cycles++;
		last_in = beats_in;
		last_out = beats_out;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[source_text_tokenizer] ERROR");
			$finish;
		end
	end

	task automatic push_byte(logic [7:0] b, logic e = 1'b0);
		src_beat_t nb;
		nb.b = b;
		nb.e = e;
		pending_bytes.push_back(nb);
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_digits(int n, int base);
		string hexd;
		hexd = "0123456789abcdefABCDEF_";
		for (int i = 0; i < n; i++)
			case (base)
				2:  push_byte($urandom_range(0, 4) == 0 ? "_" :
					8'("0" + $urandom_range(0, 1)));
				16: push_byte(hexd[$urandom_range(0, 22)]);
				default: push_byte($urandom_range(0, 5) == 0 ? "_" :
					8'("0" + $urandom_range(0, 9)));
			endcase
	endtask

	// Append one random lexical item, mostly well formed
	task automatic push_random_item();
		string letters;
		letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
		case ($urandom_range(0, 13))
			0, 1: push_text(keywords[$urandom_range(0, NKW-1)]);
			2: begin
				push_byte(letters[$urandom_range(0, 52)]);
				for (int i = $urandom_range(0, 6); i > 0; i--)
					push_byte(letters[$urandom_range(0, 62)]);
			end
			3: begin
				push_digits($urandom_range(1, 4), 10);
				if ($urandom_range(0, 1)) begin
					push_byte(".");
					push_digits($urandom_range(0, 3), 10);
				end
			end
			4: begin
				push_byte("0");
				push_byte($urandom_range(0, 1) ? "x" : "X");
				push_digits($urandom_range(0, 5), 16);
			end
			5: begin
				push_byte("0");
				push_byte($urandom_range(0, 1) ? "b" : "B");
				push_digits($urandom_range(0, 6), 2);
			end
			6: begin
				push_byte("\"");
				for (int i = $urandom_range(0, 6); i > 0; i--)
					case ($urandom_range(0, 5))
						0: push_text("\\\"");
						1: push_text("\\\\");
						2: push_byte(8'h0A);
						default: push_byte(letters[$urandom_range(0, 62)]);
					endcase
				push_byte("\"");
			end
			7, 8: push_text(operators[$urandom_range(0, 43)]);
			9: begin
				push_text("//");
				for (int i = $urandom_range(0, 5); i > 0; i--)
					push_byte(8'($urandom_range(1, 255)));
				push_byte(8'h0A);
			end
			10: begin
				push_text("/*");
				for (int i = $urandom_range(0, 5); i > 0; i--)
					push_byte($urandom_range(0, 2) == 0 ? "*" : 8'($urandom_range(1, 255)));
				push_text("*/");
			end
			11: begin
				push_digits($urandom_range(1, 2), 10);
				push_text($urandom_range(0, 1) ? ".." : ".x");
			end
			12: push_byte(8'($urandom_range(1, 255)));
			default: case ($urandom_range(0, 3))
				0: push_byte(" ");
				1: push_byte(8'h09);
				2: push_byte(8'h0D);
				default: push_byte(8'h0A);
			endcase
		endcase
		if ($urandom_range(0, 2) != 0)
			push_byte(" ");
	endtask

	// Let everything queued and predicted drain before a register write or the end of the test
	task automatic drain();
		while (pending_bytes.size() > 0 || src_in.valid || expected_tokens.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_file_id(logic [15:0] v);
		cfg.valid <= 1'b1;
		cfg.file_number <= v;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		file_id = v;
	endtask

	// Stimulus: directed text, random text in two phases, end of text
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_file_id(16'hFFFF);

		push_text("while>>>=0b1_0 9.5 7..x\"a\\\"");
		push_byte("\"");
		push_byte(8'h80);
		push_byte(8'hFF);
		push_byte(8'h01);
		drain();
		write_file_id(16'h0000);

		while (pending_bytes.size() + beats_in < RANDOM_BYTES / 2)
			push_random_item();
		drain();
		write_file_id(16'($urandom_range(1, 16'hFFFE)));

		while (pending_bytes.size() + beats_in < RANDOM_BYTES)
			push_random_item();
		// End of text with an open token of some sort
		case ($urandom_range(0, 3))
			0: push_text("\"open");
			1: push_text("/* open");
			2: push_text("42.");
			default: push_text(">>");
		endcase
		if ($urandom_range(0, 1))
			push_byte(8'h00);
		else
			push_byte(8'($urandom_range(0, 255)), 1'b1);
		push_byte(8'h00);
		push_byte(8'($urandom_range(1, 255)), 1'b1);
		push_byte(8'($urandom_range(1, 255)));
		drain();

		if (mismatches == 0)
			$display("[source_text_tokenizer] OK");
		else
			$display("[source_text_tokenizer] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tts_pkg.sv
rtl/tts_ifs.sv
rtl/tts_core.sv
rtl/tts_outq.sv
rtl/source_text_tokenizer.sv
test/testbench.sv
